// ===== rtl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, constants and command structures of the ARP cache engine.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = $clog2(Entries);

  localparam logic [31:0] TtlReset = 32'd120000;

  localparam logic [1:0] ACT_RESOLVE = 2'd0;
  localparam logic [1:0] ACT_ADD     = 2'd1;
  localparam logic [1:0] ACT_REPLY   = 2'd2;
  localparam logic [1:0] ACT_REQUEST = 2'd3;

  localparam logic [1:0] ST_EMPTY     = 2'd0;
  localparam logic [1:0] ST_REQUESTED = 2'd1;
  localparam logic [1:0] ST_USED      = 2'd2;

  localparam logic [3:0] RS_HIT      = 4'd0;
  localparam logic [3:0] RS_PENDING  = 4'd1;
  localparam logic [3:0] RS_REQUEST  = 4'd2;
  localparam logic [3:0] RS_FULL     = 4'd3;
  localparam logic [3:0] RS_PRESENT  = 4'd4;
  localparam logic [3:0] RS_FILLED   = 4'd5;
  localparam logic [3:0] RS_IGNORED  = 4'd6;
  localparam logic [3:0] RS_REPLY    = 4'd7;
  localparam logic [3:0] RS_NO_REPLY = 4'd8;

  localparam logic [1:0] CFG_MY_IP   = 2'd0;
  localparam logic [1:0] CFG_MASK    = 2'd1;
  localparam logic [1:0] CFG_GATEWAY = 2'd2;
  localparam logic [1:0] CFG_TTL     = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [31:0] target_ip;
    logic [31:0] now_ticks;
  } arp_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] result_mac;
    logic [31:0] resolved_ip;
    logic [3:0]  entry_index;
    logic        wake_waiters;
  } arp_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic scan_clr;  // reset scan index and found flags
    logic scan_step; // examine one entry
    logic write_req; // mark chosen entry requested
    logic write_fill;// fill chosen entry
    logic out_load;  // build the result register
  } arp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       scan_last;
  } arp_sts_t;

endpackage

// ===== rtl/arp_cache_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// ARP cache table engine
// Address-resolution cache with expiry and earliest-expiry eviction.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready) and each gives one result on
// the out channel (valid/ready). Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i. The user must write it only while the block is
// idle; the block itself does not enforce this. The result of an item is
// presented after the transfer cycle, a scan of the sixteen entries at one
// entry per cycle and a decision state that loads the result register. A
// table write state follows, and no new item is taken until the block is
// through with the last one.
// Reset empties every entry and loads the default registers; the table needs
// no clearing pass. A finished result waits in the output register while the
// receiver stalls; the next item is taken during that time and its result
// waits in the decision cycle until the output register is free.
// ----------------------------------------------------------------------------
module arp_cache_table_engine_top import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  arp_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output arp_out_t    out_data_o
);

  arp_cmd_t cmd;
  arp_sts_t sts;

  arp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  arp_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/arp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences capture, a table scan, the table update and result delivery.
// ----------------------------------------------------------------------------
module arp_ctrl import arp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  arp_sts_t sts_i,
  output arp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_DEC;
      end
      S_DEC: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write_req  = 1'b1;
        cmd_o.write_fill = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== rtl/arp_dpath.sv =====
// ----------------------------------------------------------------------------
// ARP cache datapath
// Entry table, configuration registers, one-entry-per-cycle scan and result.
// ----------------------------------------------------------------------------
module arp_dpath import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  arp_in_t     in_data_i,
  input  arp_cmd_t    cmd_i,
  output arp_sts_t    sts_o,
  output arp_out_t    out_data_o
);

  logic [31:0] my_ip_q, mask_q, gw_q, ttl_q;
  logic [1:0]  st_q   [Entries];
  logic [31:0] ip_q   [Entries];
  logic [47:0] mac_q  [Entries];
  logic [31:0] exp_q  [Entries];

  arp_in_t     it_q;
  logic [31:0] key_q;
  logic [IdxW-1:0] idx_q;
  logic        hit_f_q, req_f_q, free_f_q, best_f_q;
  logic [IdxW-1:0] hit_i_q, req_i_q, free_i_q, best_i_q;
  logic [31:0] best_e_q;
  logic [47:0] hit_mac_q;
  logic        do_req_q, do_fill_q;
  logic [IdxW-1:0] wr_i_q;
  arp_out_t    out_q;

  logic [31:0] key_d;
  logic [1:0]  e_st;
  logic [31:0] e_ip, e_exp;

  always_comb begin
    key_d = in_data_i.ip_addr;
    if (in_data_i.action == ACT_RESOLVE &&
        (in_data_i.ip_addr & mask_q) != (my_ip_q & mask_q))
      key_d = gw_q;
  end

  assign e_st  = st_q[idx_q];
  assign e_ip  = ip_q[idx_q];
  assign e_exp = exp_q[idx_q];

  assign sts_o.scan_last = (idx_q == IdxW'(Entries - 1));
  assign out_data_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q <= '0;
      mask_q  <= '0;
      gw_q    <= '0;
      ttl_q   <= TtlReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MY_IP:   my_ip_q <= cfg_data_i;
        CFG_MASK:    mask_q  <= cfg_data_i;
        CFG_GATEWAY: gw_q    <= cfg_data_i;
        CFG_TTL:     ttl_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q  <= in_data_i;
      key_q <= key_d;
    end
    if (cmd_i.scan_clr) begin
      idx_q    <= '0;
      hit_f_q  <= 1'b0;
      req_f_q  <= 1'b0;
      free_f_q <= 1'b0;
      best_f_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
      if (!hit_f_q && e_st == ST_USED && e_ip == key_q && it_q.now_ticks <= e_exp) begin
        hit_f_q   <= 1'b1;
        hit_i_q   <= idx_q;
        hit_mac_q <= mac_q[idx_q];
      end
      if (!req_f_q && e_st == ST_REQUESTED && e_ip == key_q) begin
        req_f_q <= 1'b1;
        req_i_q <= idx_q;
      end
      if (!free_f_q && (e_st == ST_EMPTY ||
          (e_st == ST_USED && e_exp < it_q.now_ticks))) begin
        free_f_q <= 1'b1;
        free_i_q <= idx_q;
      end
      if (e_st != ST_REQUESTED && (!best_f_q || e_exp < best_e_q)) begin
        best_f_q <= 1'b1;
        best_i_q <= idx_q;
        best_e_q <= e_exp;
      end
    end
    if (cmd_i.out_load) begin
      out_q.result_mac   <= '0;
      out_q.resolved_ip  <= key_q;
      out_q.entry_index  <= '0;
      out_q.wake_waiters <= 1'b0;
      do_req_q           <= 1'b0;
      do_fill_q          <= 1'b0;
      unique case (it_q.action)
        ACT_RESOLVE: begin
          if (hit_f_q) begin
            out_q.status      <= RS_HIT;
            out_q.result_mac  <= hit_mac_q;
            out_q.entry_index <= 4'(hit_i_q);
          end else if (req_f_q) begin
            out_q.status      <= RS_PENDING;
            out_q.entry_index <= 4'(req_i_q);
          end else if (free_f_q || best_f_q) begin
            out_q.status      <= RS_REQUEST;
            out_q.entry_index <= 4'(free_f_q ? free_i_q : best_i_q);
            wr_i_q            <= free_f_q ? free_i_q : best_i_q;
            do_req_q          <= 1'b1;
          end else begin
            out_q.status <= RS_FULL;
          end
        end
        ACT_ADD: begin
          if (hit_f_q) begin
            out_q.status      <= RS_PRESENT;
            out_q.entry_index <= 4'(hit_i_q);
          end else if (req_f_q) begin
            out_q.status       <= RS_FILLED;
            out_q.entry_index  <= 4'(req_i_q);
            out_q.wake_waiters <= 1'b1;
            wr_i_q             <= req_i_q;
            do_fill_q          <= 1'b1;
          end else if (free_f_q || best_f_q) begin
            out_q.status      <= RS_FILLED;
            out_q.entry_index <= 4'(free_f_q ? free_i_q : best_i_q);
            wr_i_q            <= free_f_q ? free_i_q : best_i_q;
            do_fill_q         <= 1'b1;
          end else begin
            out_q.status <= RS_FULL;
          end
        end
        ACT_REPLY: begin
          if (req_f_q) begin
            out_q.status       <= RS_FILLED;
            out_q.entry_index  <= 4'(req_i_q);
            out_q.wake_waiters <= 1'b1;
            wr_i_q             <= req_i_q;
            do_fill_q          <= 1'b1;
          end else begin
            out_q.status <= RS_IGNORED;
          end
        end
        default: begin
          out_q.resolved_ip <= it_q.target_ip;
          out_q.status      <= (it_q.target_ip == my_ip_q) ? RS_REPLY : RS_NO_REPLY;
        end
      endcase
    end
    if (cmd_i.write_fill && do_fill_q) begin
      ip_q[wr_i_q]  <= key_q;
      mac_q[wr_i_q] <= it_q.mac_addr;
      exp_q[wr_i_q] <= it_q.now_ticks + ttl_q;
    end else if (cmd_i.write_req && do_req_q) begin
      ip_q[wr_i_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Entries; k++) st_q[k] <= ST_EMPTY;
    end else if (cmd_i.write_fill && do_fill_q) begin
      st_q[wr_i_q] <= ST_USED;
    end else if (cmd_i.write_req && do_req_q) begin
      st_q[wr_i_q] <= ST_REQUESTED;
    end
  end

endmodule
